// File: rtl/bpwf_pkg.sv
// ----------------------------------------------------------------------------
// bpwf_pkg: shared types and constants of the battery peak window filter
// Register indexes, register widths, reset values and the config bundle.
// ----------------------------------------------------------------------------
package bpwf_pkg;

    localparam int REG_BITS = 16;
    localparam int CFG_IDX_BITS = 1;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WINDOW_LEN    = 1'd0;
    localparam t_cfg_idx CFG_HIT_THRESHOLD = 1'd1;

    localparam logic [REG_BITS-1:0] WINDOW_LEN_RESET    = 16'd600;
    localparam logic [REG_BITS-1:0] HIT_THRESHOLD_RESET = 16'd120;
    localparam logic [REG_BITS-1:0] REPEAT_MAX          = '1;

    typedef struct packed {
        logic [REG_BITS-1:0] window_len;
        logic [REG_BITS-1:0] hit_threshold;
    } t_cfg;

endpackage

// File: rtl/battery_peak_window_filter.sv
// ----------------------------------------------------------------------------
// battery_peak_window_filter: windowed peak-hold filter for battery voltage
// One filtered value per raw sample, with an output register and skid stage.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                         | transfer when
//  sample   | in        | i_valid, o_ready, i_sample      | i_valid && o_ready
//  filtered | out       | o_valid, i_ready, o_filtered    | o_valid && i_ready
//  config   | in        | i_cfg_we, i_cfg_idx, i_cfg_data | i_cfg_we
//
//  One sample per cycle while o_ready is high; each result is registered.
//  The peak state updates in the transfer cycle through one compare-and-select.
//  Synchronous active-low reset clears state, config returns to defaults.
//  Under output stall a skid entry takes one more sample, then o_ready drops.
// ----------------------------------------------------------------------------
module battery_peak_window_filter
    import bpwf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  t_cfg_idx               i_cfg_idx,
    input  logic [REG_BITS-1:0]    i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_filtered
);

    t_cfg                   r_cfg;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data;
    logic                   r_skid_valid;
    logic [SAMPLE_BITS-1:0] r_skid_data;
    logic [SAMPLE_BITS-1:0] result;
    logic                   in_xfer;
    logic                   out_xfer;

    assign o_ready    = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_data;
    assign in_xfer    = i_valid && o_ready;
    assign out_xfer   = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_len    <= WINDOW_LEN_RESET;
            r_cfg.hit_threshold <= HIT_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_LEN:    r_cfg.window_len    <= i_cfg_data;
                CFG_HIT_THRESHOLD: r_cfg.hit_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bpwf_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_load   (in_xfer),
        .i_sample (i_sample),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer) begin
            if (r_skid_valid) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end else if (in_xfer) begin
                r_out_data <= result;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid) begin
                r_out_data  <= result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output channel not empty after reset");

    a_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !r_out_valid |=> o_valid && o_filtered == $past(result))
        else $error("result not presented after transfer into empty stage");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && out_xfer |=> o_filtered == $past(r_skid_data) && o_ready)
        else $error("skid entry not moved to output");

endmodule

// File: rtl/bpwf_core.sv
// ----------------------------------------------------------------------------
// bpwf_core: peak tracking and decision datapath
// Holds the window state, forms the filtered value for the presented sample
// and advances the state when the sample is taken.
// ----------------------------------------------------------------------------
module bpwf_core
    import bpwf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_load,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_result
);

    logic [REG_BITS-1:0]    r_window_count, n_window_count;
    logic [SAMPLE_BITS-1:0] r_peak_value, n_peak_value;
    logic [SAMPLE_BITS-1:0] r_second_peak, n_second_peak;
    logic [REG_BITS-1:0]    r_peak_repeats, n_peak_repeats;
    logic [SAMPLE_BITS-1:0] r_held_value, n_held_value;

    always_comb begin
        n_window_count = r_window_count;
        n_peak_value   = r_peak_value;
        n_second_peak  = r_second_peak;
        n_peak_repeats = r_peak_repeats;
        n_held_value   = r_held_value;
        if (r_window_count < i_cfg.window_len) begin
            if (i_sample > r_peak_value) begin
                n_second_peak  = r_peak_value;
                n_peak_value   = i_sample;
                n_peak_repeats = '0;
            end else if (i_sample == r_peak_value) begin
                if (r_peak_repeats != REPEAT_MAX) begin
                    n_peak_repeats = r_peak_repeats + 1'b1;
                end
            end
            n_window_count = r_window_count + 1'b1;
        end else begin
            if (r_peak_repeats >= i_cfg.hit_threshold) begin
                n_held_value = r_peak_value;
            end else if (r_second_peak != '0) begin
                n_held_value = r_second_peak;
            end
            n_peak_value   = '0;
            n_second_peak  = '0;
            n_peak_repeats = '0;
            n_window_count = '0;
        end
        o_result = (n_held_value != '0) ? n_held_value : i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_count <= '0;
            r_peak_value   <= '0;
            r_second_peak  <= '0;
            r_peak_repeats <= '0;
            r_held_value   <= '0;
        end else if (i_load) begin
            r_window_count <= n_window_count;
            r_peak_value   <= n_peak_value;
            r_second_peak  <= n_second_peak;
            r_peak_repeats <= n_peak_repeats;
            r_held_value   <= n_held_value;
        end
    end

endmodule
